[rtl/core/sorted_priority_queue_defines.svh]
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication check, sampled on the rising clock edge
`define SPQ_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication check, sampled on the rising clock edge
`define SPQ_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/spq_pkg.sv]
// shared types and constants for the sorted priority queue
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PRI_W = 16;
    localparam int TAG_W = 8;
    localparam int OCC_W = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_PEEK   = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_FRONT,
        S_REM_RD,
        S_REM_WR
    } state_t;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } seq_status_t;

endpackage

[rtl/core/spq_store.sv]
// entry storage: one write port, one registered read port
module spq_store
    import spq_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output entry_t   rd_data
);

    entry_t mem_array [DEPTH];
    entry_t rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_array[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem_array[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/spq_seq.sv]
// sequencer with the priority comparator
module spq_seq
    import spq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        op,
    input  logic [PRI_W-1:0]  priority_req,
    input  logic [TAG_W-1:0]  tag,
    output mem_req_t          mem_req,
    input  entry_t            rd_data,
    output seq_status_t       stat,
    output logic              done,
    output logic [PRI_W-1:0]  front_priority,
    output logic [TAG_W-1:0]  front_tag,
    output logic [1:0]        status
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg, done_next;
    logic             rm_reg, rm_next;
    logic [PRI_W-1:0] pri_reg, pri_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [PRI_W-1:0] res_pri_reg, res_pri_next;
    logic [TAG_W-1:0] res_tag_reg, res_tag_next;
    status_t          res_status_reg, res_status_next;
    logic [CNT_W-1:0] idx_m1;
    logic             shift_up;

    // priority comparator: stored entry moves back when not smaller than the new one
    assign shift_up = (rd_data.pri >= pri_reg);
    assign idx_m1   = idx_reg - CNT_W'(1);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        rm_reg         <= rm_next;
        pri_reg        <= pri_next;
        tag_reg        <= tag_next;
        res_pri_reg    <= res_pri_next;
        res_tag_reg    <= res_tag_next;
        res_status_reg <= res_status_next;
    end

    // next state and memory requests
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        done_next       = 1'b0;
        rm_next         = rm_reg;
        pri_next        = pri_reg;
        tag_next        = tag_reg;
        res_pri_next    = res_pri_reg;
        res_tag_next    = res_tag_reg;
        res_status_next = res_status_reg;
        mem_req         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // raddr stays at the front slot, so a peek or remove has it next cycle
                if (start)
                begin
                    pri_next        = priority_req;
                    tag_next        = tag;
                    res_pri_next    = '0;
                    res_tag_next    = '0;
                    res_status_next = ST_OK;
                    unique case (op_t'(op))
                        OP_INSERT:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                res_status_next = ST_FULL;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        OP_PEEK, OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                rm_next    = (op_t'(op) == OP_REMOVE);
                                state_next = S_FRONT;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = '0;
                    mem_req.wdata = '{pri: pri_reg, tag: tag_reg};
                    count_next    = count_reg + CNT_W'(1);
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    mem_req.raddr = idx_m1[IDX_W-1:0];
                    state_next    = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg[IDX_W-1:0];
                if (shift_up)
                begin
                    mem_req.wdata = rd_data;
                    idx_next      = idx_m1;
                    state_next    = S_INS_RD;
                end
                else
                begin
                    mem_req.wdata = '{pri: pri_reg, tag: tag_reg};
                    count_next    = count_reg + CNT_W'(1);
                    done_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_FRONT:
            begin
                res_pri_next = rd_data.pri;
                res_tag_next = rd_data.tag;
                if (rm_reg)
                begin
                    idx_next   = CNT_W'(1);
                    state_next = S_REM_RD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REM_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_req.raddr = idx_reg[IDX_W-1:0];
                    state_next    = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_m1[IDX_W-1:0];
                mem_req.wdata = rd_data;
                idx_next      = idx_reg + CNT_W'(1);
                state_next    = S_REM_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign stat.busy      = (state_reg != S_IDLE);
    assign stat.count     = count_reg;
    assign done           = done_reg;
    assign front_priority = res_pri_reg;
    assign front_tag      = res_tag_reg;
    assign status         = res_status_reg;

endmodule

[rtl/core/sorted_priority_queue.sv]
// peek reads the front slot; remove then moves each remaining entry one slot forward
// insert moves each stored entry not smaller than the new one back, then writes it
// an empty peek or remove, a full insert or an unused op returns while idle
// throughput: one operation at a time; the next start is taken as the result beat ends
// the result beat is shown for one cycle on done; the receiver cannot stall it
// reset clears the count, the state and done; entry storage and results are not cleared
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        op,
    input  logic [PRI_W-1:0]  priority_req,
    input  logic [TAG_W-1:0]  tag,
    output logic              done,
    output logic [PRI_W-1:0]  front_priority,
    output logic [TAG_W-1:0]  front_tag,
    output logic [1:0]        status,
    output logic [OCC_W-1:0]  occupancy
);

    mem_req_t    mem_req;
    entry_t      rd_data;
    seq_status_t stat;

    // entry storage
    spq_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // operation sequencer
    spq_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .op             (op),
        .priority_req   (priority_req),
        .tag            (tag),
        .mem_req        (mem_req),
        .rd_data        (rd_data),
        .stat           (stat),
        .done           (done),
        .front_priority (front_priority),
        .front_tag      (front_tag),
        .status         (status)
    );

    // handshake and occupancy view
    assign busy      = stat.busy;
    assign occupancy = OCC_W'(stat.count);

    // checks
    `SPQ_CHECK(a_count_bound, 1'b1, stat.count <= CNT_W'(DEPTH), "count above depth")
    `SPQ_CHECK_NEXT(a_accept_progress, start && !busy, busy || done, "accepted beat lost")
    `SPQ_CHECK(a_done_idle, done, !busy, "result beat while busy")
    `SPQ_CHECK(a_full_count, done && (status == ST_FULL), stat.count == CNT_W'(DEPTH),
        "full status with free slots")
    `SPQ_CHECK(a_empty_count, done && (status == ST_EMPTY), stat.count == '0,
        "empty status with stored entries")

endmodule

[tb/sorted_priority_queue_checker.sv]
// result predictor and scoreboard for the sorted priority queue
module sorted_priority_queue_checker
    import spq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [1:0]        op,
    input  logic [PRI_W-1:0]  priority_req,
    input  logic [TAG_W-1:0]  tag,
    input  logic              done,
    input  logic [PRI_W-1:0]  front_priority,
    input  logic [TAG_W-1:0]  front_tag,
    input  logic [1:0]        status,
    input  logic [OCC_W-1:0]  occupancy,
    output int                mismatches,
    output int                pending
);

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [TAG_W-1:0] tag;
        status_t          st;
        logic [OCC_W-1:0] occ;
    } queue_result_t;

    // model copy of the sorted list, slot 0 at the front
    logic [PRI_W-1:0] slot_pri [DEPTH];
    logic [TAG_W-1:0] slot_tag [DEPTH];
    int               slot_count;

    queue_result_t    awaited_q [$];
    int               err_count;

    // apply one command to the sorted list and return the beat it must produce
    function automatic queue_result_t apply_queue_op(input logic [1:0] cmd,
                                                     input logic [PRI_W-1:0] pri,
                                                     input logic [TAG_W-1:0] tg);
        queue_result_t r;
        int            pos;
        r = '0;
        r.st = ST_OK;
        case (cmd)
            OP_INSERT:
            begin
                if (slot_count >= DEPTH)
                begin
                    r.st = ST_FULL;
                end
                else
                begin
                    // new entry goes ahead of equal priorities
                    pos = 0;
                    while (pos < slot_count && slot_pri[pos] < pri)
                        pos++;
                    for (int i = slot_count; i > pos; i--)
                    begin
                        slot_pri[i] = slot_pri[i-1];
                        slot_tag[i] = slot_tag[i-1];
                    end
                    slot_pri[pos] = pri;
                    slot_tag[pos] = tg;
                    slot_count++;
                end
            end
            OP_PEEK, OP_REMOVE:
            begin
                if (slot_count == 0)
                begin
                    r.st = ST_EMPTY;
                end
                else
                begin
                    r.pri = slot_pri[0];
                    r.tag = slot_tag[0];
                    if (cmd == OP_REMOVE)
                    begin
                        for (int i = 1; i < slot_count; i++)
                        begin
                            slot_pri[i-1] = slot_pri[i];
                            slot_tag[i-1] = slot_tag[i];
                        end
                        slot_count--;
                    end
                end
            end
            default:
            begin
                // unused code: no change
            end
        endcase
        r.occ = OCC_W'(slot_count);
        return r;
    endfunction

    // compare result beats first, then predict the command beat of this edge
    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t got;
        queue_result_t want;
        if (!rst_n)
        begin
            slot_count = 0;
            awaited_q.delete();
            err_count = 0;
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                got.pri = front_priority;
                got.tag = front_tag;
                got.st  = status_t'(status);
                got.occ = occupancy;
                if (awaited_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing awaited: pri %h tag %h st %0d occ %0d",
                             $time, got.pri, got.tag, got.st, got.occ);
                    err_count++;
                end
                else
                begin
                    want = awaited_q.pop_front();
                    if (got.pri !== want.pri)
                    begin
                        $display("%0t: front_priority expected %h actual %h",
                                 $time, want.pri, got.pri);
                        err_count++;
                    end
                    if (got.tag !== want.tag)
                    begin
                        $display("%0t: front_tag expected %h actual %h",
                                 $time, want.tag, got.tag);
                        err_count++;
                    end
                    if (status !== want.st)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, status);
                        err_count++;
                    end
                    if (got.occ !== want.occ)
                    begin
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, want.occ, got.occ);
                        err_count++;
                    end
                end
            end
            if (start && !busy)
                awaited_q.push_back(apply_queue_op(op, priority_req, tag));
            mismatches <= err_count;
            pending <= awaited_q.size();
        end
    end

endmodule

[tb/sorted_priority_queue_tb.sv]
// stimulus and verdict for the sorted priority queue
module sorted_priority_queue_tb;
    import spq_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       op;
    logic [PRI_W-1:0] priority_req;
    logic [TAG_W-1:0] tag;
    logic             done;
    logic [PRI_W-1:0] front_priority;
    logic [TAG_W-1:0] front_tag;
    logic [1:0]       status;
    logic [OCC_W-1:0] occupancy;
    int               mismatches;
    int               pending;
    int               idle_pct;

    sorted_priority_queue u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .priority_req   (priority_req),
        .tag            (tag),
        .done           (done),
        .front_priority (front_priority),
        .front_tag      (front_tag),
        .status         (status),
        .occupancy      (occupancy)
    );

    sorted_priority_queue_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .priority_req   (priority_req),
        .tag            (tag),
        .done           (done),
        .front_priority (front_priority),
        .front_tag      (front_tag),
        .status         (status),
        .occupancy      (occupancy),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // drive one command beat, with random idle cycles ahead of it
    task automatic issue_cmd(input logic [1:0] cmd, input logic [PRI_W-1:0] pri,
                             input logic [TAG_W-1:0] tg);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        op           <= cmd;
        priority_req <= pri;
        tag          <= tg;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // priorities: a narrow band for ties most often, also full range and extremes
    function automatic logic [PRI_W-1:0] pick_priority();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45)
            return PRI_W'($urandom_range(7));
        else if (sel < 80)
            return PRI_W'($urandom);
        else if (sel < 90)
            return '1;
        else
            return '0;
    endfunction

    // pick a command, at times the unused code, weighted by the current fill or drain trend
    function automatic logic [1:0] pick_cmd(input int trend);
        int sel;
        sel = $urandom_range(99);
        if (sel < 3)
            return 2'd3;
        case (trend)
            0:       return (sel < 80) ? OP_INSERT : ((sel < 90) ? OP_PEEK : OP_REMOVE);
            1:       return (sel < 20) ? OP_INSERT : ((sel < 35) ? OP_PEEK : OP_REMOVE);
            default: return (sel < 50) ? OP_INSERT : ((sel < 65) ? OP_PEEK : OP_REMOVE);
        endcase
    endfunction

    // reset, directed part, random part, drain and verdict
    initial
    begin
        int trend;
        int seg_left;
        int pct_plan [3];
        pct_plan[0] = 24;
        pct_plan[1] = 82;
        pct_plan[2] = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = OP_INSERT;
        priority_req = '0;
        tag          = '0;
        idle_pct     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: peek, remove, unused code
        idle_pct = 24;
        issue_cmd(OP_PEEK, 16'h1234, 8'h12);
        issue_cmd(OP_REMOVE, 16'hffff, 8'hff);
        issue_cmd(2'd3, 16'hffff, 8'hff);
        // fill with extremes and ties
        issue_cmd(OP_INSERT, 16'hffff, 8'hff);
        issue_cmd(OP_INSERT, 16'h0000, 8'h00);
        issue_cmd(OP_INSERT, 16'h8000, 8'haa);
        issue_cmd(OP_INSERT, 16'h8000, 8'h55);
        issue_cmd(OP_INSERT, 16'h0000, 8'h01);
        issue_cmd(OP_INSERT, 16'hffff, 8'h80);
        for (int i = 0; i < 10; i++)
            issue_cmd(OP_INSERT, pick_priority(), 8'($urandom));
        // full queue: insert dropped, unused code, peek, removes
        issue_cmd(OP_INSERT, 16'h0000, 8'h77);
        issue_cmd(2'd3, 16'h0000, 8'h00);
        issue_cmd(OP_PEEK, 16'h0000, 8'h00);
        issue_cmd(OP_REMOVE, 16'h0000, 8'h00);
        issue_cmd(OP_REMOVE, 16'h0000, 8'h00);
        issue_cmd(OP_REMOVE, 16'h0000, 8'h00);

        // random part in three idling phases, trend segments push to full and empty
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = pct_plan[ph];
            trend = 0;
            seg_left = 0;
            for (int n = 0; n < 234; n++)
            begin
                if (seg_left == 0)
                begin
                    trend = $urandom_range(2);
                    seg_left = $urandom_range(40, 8);
                end
                seg_left--;
                issue_cmd(pick_cmd(trend), pick_priority(), 8'($urandom));
            end
        end
        start <= 1'b0;

        // drain outstanding results
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule

[sorted_priority_queue.f]
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_store.sv
rtl/core/spq_seq.sv
rtl/core/sorted_priority_queue.sv
tb/sorted_priority_queue_checker.sv
tb/sorted_priority_queue_tb.sv
